// ----- rtl/core/wrc_pkg.sv -----
// Shared types and constants of the WAV RIFF chunk parser.
`default_nettype none

package wrc_pkg;

	// Chunk tags as they read when four little-endian bytes are packed
	localparam logic [31:0] TAG_RIFF = 32'h46464952;
	localparam logic [31:0] TAG_WAVE = 32'h45564157;
	localparam logic [31:0] TAG_FMT  = 32'h20746d66;
	localparam logic [31:0] TAG_DATA = 32'h61746164;

	localparam logic [15:0] FMT_PCM = 16'd1;

	// Sticky status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOT_WAVE = 2'd1;
	localparam logic [1:0] ST_NOT_PCM  = 2'd2;

	// Bytes of the fmt body that are captured
	localparam int FMT_CAP_BYTES = 16;

	// x / 1000 == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
	localparam logic [31:0] DIV_MAGIC = 32'h10624DD3;
	localparam int          DIV_SHIFT = 38;
	localparam int          QUOT_W    = 64 - DIV_SHIFT;

	// Front/back queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		PH_RIFF,
		PH_HDR,
		PH_FMT,
		PH_DATA,
		PH_SKIP,
		PH_PAD,
		PH_HALT
	} wrc_phase_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL_A,
		BK_MUL_B,
		BK_DIV,
		BK_FIN
	} wrc_back_state_t;

	typedef struct packed {
		logic [7:0] in_byte;
	} wrc_byte_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        payload_valid;
		logic        format_valid;
		logic [15:0] channel_count;
		logic [31:0] sampling_hz;
		logic [15:0] bits_per_sample;
		logic [31:0] bytes_per_ms;
		logic [31:0] data_length;
		logic [1:0]  parse_status;
		logic        stream_complete;
	} wrc_result_t;

	// One classified byte on its way from front to back
	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        payload_valid;
		logic        commit;
		logic [15:0] ch;
		logic [31:0] rate;
		logic [15:0] bits;
		logic [31:0] data_length;
		logic [1:0]  status;
		logic        complete;
	} wrc_entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/wrc_byte_if.sv -----
// Byte input channel: valid/ready handshake carrying one file byte.
`default_nettype none

interface wrc_byte_if;
	import wrc_pkg::*;

	logic      valid;
	logic      ready;
	wrc_byte_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wrc_result_if.sv -----
// Result channel: valid/ready handshake carrying one parser result.
`default_nettype none

interface wrc_result_if;
	import wrc_pkg::*;

	logic        valid;
	logic        ready;
	wrc_result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wrc_front.sv -----
// Front end: byte-wise RIFF/WAVE header and chunk walker.
`default_nettype none

module wrc_front (
	input  logic               clk,
	input  logic               arst_n,
	wrc_byte_if.sink           byte_stream,
	output logic               push_valid,
	input  logic               push_ready,
	output wrc_pkg::wrc_entry_t push_data
);
	import wrc_pkg::*;

	logic [31:0] byte_count_q, riff_size_q, tag_q, remain_q, data_len_q;
	wrc_phase_t  phase_q;
	logic [4:0]  hdr_idx_q;
	logic        pad_q;
	logic [1:0]  status_q;
	logic [FMT_CAP_BYTES-1:0][7:0] cap_q;

	logic [31:0] n_count, n_riff, n_tag, n_rem, n_dlen, size;
	wrc_phase_t  n_phase;
	logic [4:0]  n_idx;
	logic        n_pad;
	logic [1:0]  n_status;
	logic [FMT_CAP_BYTES-1:0][7:0] n_cap;
	logic [7:0]  b;
	logic [1:0]  lane;
	logic        valid, begin_b, do_end, commit, complete, accept;

	assign b      = byte_stream.payload.in_byte;
	assign lane   = hdr_idx_q[1:0];
	assign accept = byte_stream.valid && push_ready;

	assign byte_stream.ready = push_ready;
	assign push_valid        = byte_stream.valid;

	always_comb begin
		n_count  = (byte_count_q == '1) ? byte_count_q : byte_count_q + 32'd1;
		n_riff   = riff_size_q;
		n_tag    = tag_q;
		n_rem    = remain_q;
		n_dlen   = data_len_q;
		n_phase  = phase_q;
		n_idx    = hdr_idx_q;
		n_pad    = pad_q;
		n_status = status_q;
		n_cap    = cap_q;
		valid    = 1'b0;
		begin_b  = 1'b0;
		do_end   = 1'b0;
		commit   = 1'b0;
		size     = '0;

		unique case (phase_q)
			PH_RIFF: begin
				if (hdr_idx_q < 5'd4) begin
					if (lane == 2'd0) n_tag = '0;
					n_tag[{lane, 3'b000} +: 8] = b;
				end else if (hdr_idx_q < 5'd8) begin
					if (lane == 2'd0) n_riff = '0;
					n_riff[{lane, 3'b000} +: 8] = b;
				end else begin
					if (lane == 2'd0) n_rem = '0;
					n_rem[{lane, 3'b000} +: 8] = b;
				end
				if (hdr_idx_q >= 5'd11) begin
					if (n_tag != TAG_RIFF || n_rem != TAG_WAVE) begin
						n_status = ST_NOT_WAVE;
						n_phase  = PH_HALT;
					end else begin
						n_phase = PH_HDR;
						n_idx   = '0;
						n_tag   = '0;
						n_rem   = '0;
					end
				end else begin
					n_idx = hdr_idx_q + 5'd1;
				end
			end
			PH_HDR: begin
				if (!hdr_idx_q[2]) begin
					if (lane == 2'd0) n_tag = '0;
					n_tag[{lane, 3'b000} +: 8] = b;
				end else begin
					if (lane == 2'd0) n_rem = '0;
					n_rem[{lane, 3'b000} +: 8] = b;
				end
				n_idx = hdr_idx_q + 5'd1;
				if (hdr_idx_q[2:0] == 3'd7) begin
					n_idx   = '0;
					begin_b = 1'b1;
				end
			end
			PH_FMT: begin
				if (hdr_idx_q < 5'(FMT_CAP_BYTES)) begin
					n_cap[hdr_idx_q[3:0]] = b;
					n_idx = hdr_idx_q + 5'd1;
				end
				n_rem = remain_q - 32'd1;
				do_end = (remain_q == 32'd1);
			end
			PH_DATA: begin
				valid  = 1'b1;
				n_rem  = remain_q - 32'd1;
				do_end = (remain_q == 32'd1);
			end
			PH_SKIP: begin
				n_rem  = remain_q - 32'd1;
				do_end = (remain_q == 32'd1);
			end
			PH_PAD: begin
				n_pad   = 1'b0;
				n_idx   = '0;
				n_phase = PH_HDR;
			end
			PH_HALT: ;
			default: ;
		endcase

		// chunk header done: classify the body
		if (begin_b) begin
			size = n_rem;
			if (n_tag == TAG_DATA) begin
				n_dlen  = size;
				n_phase = PH_DATA;
			end else begin
				if (size[31]) size = '0;
				if (n_tag == TAG_FMT) begin
					n_cap   = '0;
					n_idx   = '0;
					n_phase = PH_FMT;
				end else begin
					n_phase = PH_SKIP;
				end
			end
			n_pad = size[0];
			n_rem = size;
			do_end = (size == 32'd0);
		end

		// body done: fmt check, then pad or next header
		if (do_end) begin
			if (n_phase == PH_FMT && {n_cap[1], n_cap[0]} != FMT_PCM) begin
				n_status = ST_NOT_PCM;
				n_phase  = PH_HALT;
			end else begin
				commit  = (n_phase == PH_FMT);
				n_idx   = '0;
				n_phase = n_pad ? PH_PAD : PH_HDR;
			end
		end

		complete = (n_status == ST_OK) && (n_phase != PH_RIFF) &&
			({1'b0, n_count} >= ({1'b0, n_riff} + 33'd8));
	end

	always_comb begin
		push_data.payload_byte  = b;
		push_data.payload_valid = valid;
		push_data.commit        = commit;
		push_data.ch            = {n_cap[3], n_cap[2]};
		push_data.rate          = {n_cap[7], n_cap[6], n_cap[5], n_cap[4]};
		push_data.bits          = {n_cap[15], n_cap[14]};
		push_data.data_length   = n_dlen;
		push_data.status        = n_status;
		push_data.complete      = complete;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			riff_size_q  <= '0;
			tag_q        <= '0;
			remain_q     <= '0;
			data_len_q   <= '0;
			phase_q      <= PH_RIFF;
			hdr_idx_q    <= '0;
			pad_q        <= 1'b0;
			status_q     <= ST_OK;
			cap_q        <= '0;
		end else if (accept) begin
			byte_count_q <= n_count;
			riff_size_q  <= n_riff;
			tag_q        <= n_tag;
			remain_q     <= n_rem;
			data_len_q   <= n_dlen;
			phase_q      <= n_phase;
			hdr_idx_q    <= n_idx;
			pad_q        <= n_pad;
			status_q     <= n_status;
			cap_q        <= n_cap;
		end
	end
endmodule

`default_nettype wire

// ----- rtl/core/wrc_queue.sv -----
// Short FIFO of classified items between front and back.
`default_nettype none

module wrc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  wrc_pkg::wrc_entry_t push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output wrc_pkg::wrc_entry_t pop_data
);
	import wrc_pkg::*;

	wrc_entry_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push, pop;

	assign push_ready = (cnt_q != (QPTR_W + 1)'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

`default_nettype wire

// ----- rtl/core/wrc_back.sv -----
// Back end: format arithmetic, published format registers and result register.
`default_nettype none

module wrc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  wrc_pkg::wrc_entry_t pop_data,
	wrc_result_if.source        result
);
	import wrc_pkg::*;

	wrc_back_state_t st_q, st_d;
	wrc_entry_t      hold_q, src;
	wrc_result_t     out_q;
	logic            out_valid_q, out_free, load, use_new;

	logic [31:0] m1_q, p_q, mag, per_new;
	logic [47:0] m1_full;
	logic [44:0] p_full;
	logic [63:0] prod;
	logic [QUOT_W-1:0] quot_q;
	logic        neg_q;

	// published format
	logic        fmt_ok_q;
	logic [15:0] ch_q, bits_q;
	logic [31:0] rate_q, per_q;

	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= BK_IDLE;
		else st_q <= st_d;
	end

	always_comb begin
		st_d      = st_q;
		pop_ready = 1'b0;
		load      = 1'b0;
		use_new   = 1'b0;
		unique case (st_q)
			BK_IDLE: begin
				if (pop_valid) begin
					if (pop_data.commit) begin
						pop_ready = 1'b1;
						st_d      = BK_MUL_A;
					end else if (out_free) begin
						pop_ready = 1'b1;
						load      = 1'b1;
					end
				end
			end
			BK_MUL_A: st_d = BK_MUL_B;
			BK_MUL_B: st_d = BK_DIV;
			BK_DIV:   st_d = BK_FIN;
			BK_FIN: begin
				if (out_free) begin
					load    = 1'b1;
					use_new = 1'b1;
					st_d    = BK_IDLE;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	// rate * ch * (bits >> 3), wrapping at 32 bits, then signed / 1000
	assign m1_full = hold_q.rate * hold_q.ch;
	assign p_full  = m1_q * hold_q.bits[15:3];
	assign mag     = p_q[31] ? (32'd0 - p_q) : p_q;
	assign prod    = mag * DIV_MAGIC;
	assign per_new = neg_q ? (32'd0 - {(32 - QUOT_W)'(0), quot_q})
		: {(32 - QUOT_W)'(0), quot_q};

	always_ff @(posedge clk) begin
		if (st_q == BK_IDLE && pop_ready && pop_data.commit) hold_q <= pop_data;
		if (st_q == BK_MUL_A) m1_q <= m1_full[31:0];
		if (st_q == BK_MUL_B) p_q <= p_full[31:0];
		if (st_q == BK_DIV) begin
			quot_q <= prod[63:DIV_SHIFT];
			neg_q  <= p_q[31];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_ok_q <= 1'b0;
			ch_q     <= '0;
			rate_q   <= '0;
			bits_q   <= '0;
			per_q    <= '0;
		end else if (load && use_new) begin
			fmt_ok_q <= 1'b1;
			ch_q     <= hold_q.ch;
			rate_q   <= hold_q.rate;
			bits_q   <= hold_q.bits;
			per_q    <= per_new;
		end
	end

	assign src = use_new ? hold_q : pop_data;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.payload_byte    <= src.payload_byte;
			out_q.payload_valid   <= src.payload_valid;
			out_q.data_length     <= src.data_length;
			out_q.parse_status    <= src.status;
			out_q.stream_complete <= src.complete;
			out_q.format_valid    <= use_new ? 1'b1 : fmt_ok_q;
			out_q.channel_count   <= use_new ? hold_q.ch : ch_q;
			out_q.sampling_hz     <= use_new ? hold_q.rate : rate_q;
			out_q.bits_per_sample <= use_new ? hold_q.bits : bits_q;
			out_q.bytes_per_ms    <= use_new ? per_new : per_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (load) out_valid_q <= 1'b1;
		else if (result.ready) out_valid_q <= 1'b0;
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;
endmodule

`default_nettype wire

// ----- rtl/core/wav_riff_chunk_parser_unit.sv -----
// Top level of the WAV RIFF chunk parser.
`default_nettype none

// Parses a WAV file presented one byte per item on byte_stream and returns one
// result item per byte on result. The byte is echoed in payload_byte, with
// payload_valid set inside data chunk bodies; the other fields show the format
// taken from the last PCM fmt chunk, bytes per millisecond (signed quotient of
// the 32-bit wrapped product rate * channels * (bits / 8) by 1000), the size of
// the latest data chunk, a sticky status (1: not RIFF/WAVE, 2: not PCM) and
// stream_complete once the byte count reaches the RIFF size plus 8 with the
// status OK. On a bad header or a non-PCM fmt chunk the parser stops and only
// echoes bytes. Throughput is one byte per cycle while no PCM fmt chunk closes
// and result is not stalled: the front parser classifies each byte
// combinationally as it is accepted and the back takes one queued item a cycle
// while its output register is free. A byte is written into the queue when it
// is accepted and, once it is at the head of the queue and the output register
// is free, loaded into the output register, from which its result is offered.
// A byte that closes a PCM fmt chunk instead passes through the back states
// MUL_A, MUL_B, DIV and FIN (two multiplies, a reciprocal multiply for the
// divide by 1000, then the output load), where an ordinary byte is loaded as
// it is popped. The four-item queue lets the front keep accepting while it has
// room, but the back also takes only one item a cycle, so the backlog clears
// only through gaps in the input; each such byte can stall an unbroken stream.
// No clearing pass is needed after reset.

module wav_riff_chunk_parser_unit (
	input  logic         clk,
	input  logic         arst_n,
	wrc_byte_if.sink     byte_stream,
	wrc_result_if.source result
);
	import wrc_pkg::*;

	// front -> queue
	logic       f_valid, f_ready;
	wrc_entry_t f_data;
	// queue -> back
	logic       b_valid, b_ready;
	wrc_entry_t b_data;

	// header and chunk walker, one byte a cycle while the queue has room
	wrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_stream(byte_stream),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data)
	);

	// decouples the parser from the arithmetic and the result stall
	wrc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data (f_data),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (b_data)
	);

	// format arithmetic and the result register
	wrc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(b_valid),
		.pop_ready(b_ready),
		.pop_data (b_data),
		.result   (result)
	);
endmodule

`default_nettype wire

// ----- rtl/core/wrc_checker.sv -----
// Port-level checks of the WAV RIFF chunk parser, bound to the top level.
`default_nettype none

module wrc_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input wrc_pkg::wrc_result_t out_payload
);
	import wrc_pkg::*;

	logic       in_acc, out_acc;
	logic [3:0] pending_q;
	logic [1:0] last_status_q;
	logic       fmt_seen_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q     <= '0;
			last_status_q <= ST_OK;
			fmt_seen_q    <= 1'b0;
		end else begin
			if (in_acc && !out_acc) pending_q <= pending_q + 4'd1;
			else if (out_acc && !in_acc) pending_q <= pending_q - 4'd1;
			if (out_acc) begin
				last_status_q <= out_payload.parse_status;
				fmt_seen_q    <= fmt_seen_q || out_payload.format_valid;
			end
		end
	end

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("result changed while stalled");

	// no result without an earlier byte
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pending_q != 4'd0)
		else $error("result without an accepted byte");

	// an error stops the parser for good
	a_status_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && last_status_q != ST_OK |->
			out_payload.parse_status == last_status_q && !out_payload.payload_valid)
		else $error("status not sticky after error");

	// once a format is published it stays
	a_fmt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && fmt_seen_q |-> out_payload.format_valid)
		else $error("format_valid dropped");
endmodule

bind wav_riff_chunk_parser_unit wrc_checker u_wrc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (byte_stream.valid),
	.in_ready   (byte_stream.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_payload(result.payload)
);

`default_nettype wire
